// ----- hdl/rrrn_pkg.sv -----
// Shared constants, types and codes for the rotating ring remove-nearest block.
package rrrn_pkg;

  localparam int CAPACITY    = 128;
  localparam int VALUE_BITS  = 16;
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  localparam int ROT_BITS    = 7;
  localparam int STATUS_BITS = 2;

  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [VALUE_BITS-1:0]  value_t;
  typedef logic [ROT_BITS-1:0]    rot_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam logic MODE_PUSH   = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NOT_FOUND = 2'd1;
  localparam status_t STATUS_FULL      = 2'd2;

endpackage

// ----- hdl/rotating_ring_remove_nearest_top.sv -----
// Rotating ring with remove-nearest: a doubly linked ring of values in a slot table.
// A push (mode 0) appends item_value behind the back entry; a remove (mode 1) walks
// forward from the front to the first equal entry at distance d, answers the shorter
// rotation (d if d <= count/2, else count - d), unlinks that entry and makes its
// successor the new front. Missing values answer status 1, pushes into a full ring are
// dropped with status 2. One item is in work at a time; in_stall stays high until its
// result has been loaded into the output register. A push steps the allocation cursor
// over the slots, one valid bit per cycle, until it finds a free one. A remove walks the
// link RAM forward through its single registered read port, one entry per cycle, so a
// miss walks the whole ring. A full-ring push or a remove from an empty ring skips the
// scan and the walk and goes straight to the response. Every result waits there while
// the output register is stalled. No clearing pass is needed after reset.
module rotating_ring_remove_nearest_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [15:0]              item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [6:0]               rotations,
  output logic [1:0]               status
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_PUSH_W1 = 3'd2;
  localparam logic [2:0] ST_PUSH_W2 = 3'd3;
  localparam logic [2:0] ST_WALK    = 3'd4;
  localparam logic [2:0] ST_REM_W   = 3'd5;
  localparam logic [2:0] ST_RESP    = 3'd6;

  logic [2:0] state;

  rrrn_pkg::value_t  item_val;
  rrrn_pkg::slot_t   slot;
  rrrn_pkg::slot_t   cur;
  rrrn_pkg::slot_t   nx;
  rrrn_pkg::slot_t   pv;
  rrrn_pkg::count_t  walk_dist;
  rrrn_pkg::count_t  res_rot;
  rrrn_pkg::status_t res_status;

  rrrn_pkg::slot_t  front_slot;
  rrrn_pkg::slot_t  back_slot;
  rrrn_pkg::count_t entry_count;
  rrrn_pkg::slot_t  alloc_cursor;
  logic [rrrn_pkg::CAPACITY-1:0] entry_valid;

  // RAM ports
  rrrn_pkg::slot_t  rd_addr;
  rrrn_pkg::value_t val_rdata;
  rrrn_pkg::slot_t  next_rdata;
  rrrn_pkg::slot_t  prev_rdata;
  logic             val_we;
  logic             next_we;
  logic             prev_we;
  rrrn_pkg::slot_t  next_waddr;
  rrrn_pkg::slot_t  next_wdata;
  rrrn_pkg::slot_t  prev_waddr;
  rrrn_pkg::slot_t  prev_wdata;

  logic             accept;
  logic             out_free;
  logic             hit;
  rrrn_pkg::count_t half_count;
  rrrn_pkg::count_t dist_rot;
  rrrn_pkg::slot_t  scan_next;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign hit        = (val_rdata == item_val);
  assign half_count = entry_count >> 1;
  assign dist_rot   = (walk_dist <= half_count) ? walk_dist : entry_count - walk_dist;
  assign scan_next  = (slot == rrrn_pkg::slot_t'(rrrn_pkg::CAPACITY - 1)) ?
                      '0 : slot + rrrn_pkg::slot_t'(1);

  // the walk chases the link just read, so the next address comes straight off the RAM
  assign rd_addr = (state == ST_WALK) ? next_rdata : front_slot;

  always_comb begin
    val_we     = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = slot;
    next_wdata = slot;
    prev_waddr = slot;
    prev_wdata = slot;
    unique case (state)
      ST_PUSH_W1: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        if (entry_count != '0) begin
          next_wdata = front_slot;
          prev_wdata = back_slot;
        end
      end
      ST_PUSH_W2: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = back_slot;
        prev_waddr = front_slot;
      end
      ST_REM_W: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = pv;
        next_wdata = nx;
        prev_waddr = nx;
        prev_wdata = pv;
      end
      default: begin
      end
    endcase
  end

  rrrn_ram #(.WIDTH(rrrn_pkg::VALUE_BITS), .DEPTH(rrrn_pkg::CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot),
    .wdata (item_val),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  rrrn_ram #(.WIDTH(rrrn_pkg::SLOT_BITS), .DEPTH(rrrn_pkg::CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rdata)
  );

  rrrn_ram #(.WIDTH(rrrn_pkg::SLOT_BITS), .DEPTH(rrrn_pkg::CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

  // control and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      front_slot   <= '0;
      back_slot    <= '0;
      entry_count  <= '0;
      alloc_cursor <= rrrn_pkg::slot_t'(rrrn_pkg::CAPACITY - 1);
      entry_valid  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item_val  <= item_value;
            cur       <= front_slot;
            walk_dist <= '0;
            res_rot   <= '0;
            if (mode == rrrn_pkg::MODE_PUSH) begin
              if (entry_count == rrrn_pkg::count_t'(rrrn_pkg::CAPACITY)) begin
                res_status <= rrrn_pkg::STATUS_FULL;
                state      <= ST_RESP;
              end else begin
                slot  <= (alloc_cursor == rrrn_pkg::slot_t'(rrrn_pkg::CAPACITY - 1)) ?
                         '0 : alloc_cursor + rrrn_pkg::slot_t'(1);
                state <= ST_SCAN;
              end
            end else begin
              if (entry_count == '0) begin
                res_status <= rrrn_pkg::STATUS_NOT_FOUND;
                state      <= ST_RESP;
              end else begin
                state <= ST_WALK;
              end
            end
          end
        end
        ST_SCAN: begin
          if (!entry_valid[slot]) begin
            state <= ST_PUSH_W1;
          end else begin
            slot <= scan_next;
          end
        end
        ST_PUSH_W1: begin
          alloc_cursor      <= slot;
          entry_valid[slot] <= 1'b1;
          entry_count       <= entry_count + rrrn_pkg::count_t'(1);
          res_status        <= rrrn_pkg::STATUS_OK;
          if (entry_count == '0) begin
            front_slot  <= slot;
            back_slot   <= slot;
            state       <= ST_RESP;
          end else begin
            state <= ST_PUSH_W2;
          end
        end
        ST_PUSH_W2: begin
          back_slot   <= slot;
          state       <= ST_RESP;
        end
        ST_WALK: begin
          if (hit) begin
            nx         <= next_rdata;
            pv         <= prev_rdata;
            res_rot    <= dist_rot;
            res_status <= rrrn_pkg::STATUS_OK;
            state      <= ST_REM_W;
          end else if (walk_dist == entry_count - rrrn_pkg::count_t'(1)) begin
            res_status <= rrrn_pkg::STATUS_NOT_FOUND;
            state      <= ST_RESP;
          end else begin
            cur       <= next_rdata;
            walk_dist <= walk_dist + rrrn_pkg::count_t'(1);
          end
        end
        ST_REM_W: begin
          entry_valid[cur] <= 1'b0;
          front_slot       <= nx;
          back_slot        <= pv;
          entry_count      <= entry_count - rrrn_pkg::count_t'(1);
          state            <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      rotations <= rrrn_pkg::rot_t'(res_rot);
      status    <= res_status;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(entry_count))
    else $error("entry_count disagrees with valid bits");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= rrrn_pkg::count_t'(rrrn_pkg::CAPACITY))
    else $error("entry_count above capacity");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> walk_dist < entry_count)
    else $error("walk distance past ring length");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result presented outside response state");

  a_scan_has_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> entry_count < rrrn_pkg::count_t'(rrrn_pkg::CAPACITY))
    else $error("slot scan started on a full ring");

endmodule

// ----- hdl/rrrn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rrrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- dv/rotating_ring_remove_nearest_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the rotating ring block: directed and random traffic against a ring model.
module rotating_ring_remove_nearest_top_tb;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    rrrn_pkg::rot_t    rot;
    rrrn_pkg::status_t st;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = rrrn_pkg::MODE_PUSH;
  rrrn_pkg::value_t  item_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rrrn_pkg::rot_t    rotations;
  rrrn_pkg::status_t status;

  rotating_ring_remove_nearest_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rotations  (rotations),
    .status     (status)
  );

  // ring model: slot table with forward/backward links
  rrrn_pkg::value_t ring_val  [rrrn_pkg::CAPACITY];
  rrrn_pkg::slot_t  ring_next [rrrn_pkg::CAPACITY];
  rrrn_pkg::slot_t  ring_prev [rrrn_pkg::CAPACITY];
  bit               ring_used [rrrn_pkg::CAPACITY];
  rrrn_pkg::slot_t  ring_front;
  rrrn_pkg::slot_t  ring_back;
  rrrn_pkg::slot_t  ring_cursor;
  rrrn_pkg::count_t ring_count;

  ring_result_t pending_results[$];
  ring_result_t oldest;
  int           mismatches = 0;
  bit           quiet = 1'b0;
  int           hold_req = 0;
  int           run_left = 0;
  bit           run_stalled = 1'b0;
  int           stall_roll;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void ring_clear();
    foreach (ring_used[i]) ring_used[i] = 1'b0;
    ring_front  = '0;
    ring_back   = '0;
    ring_count  = '0;
    ring_cursor = rrrn_pkg::slot_t'(rrrn_pkg::CAPACITY - 1);
  endfunction

  function automatic ring_result_t ring_apply(logic op, rrrn_pkg::value_t v);
    ring_result_t    r;
    rrrn_pkg::slot_t s;
    rrrn_pkg::slot_t cur;
    rrrn_pkg::slot_t nx;
    rrrn_pkg::slot_t pv;
    int              d;
    bit              hit;
    r.rot = '0;
    r.st  = rrrn_pkg::STATUS_OK;
    if (op == rrrn_pkg::MODE_PUSH) begin
      if (ring_count >= rrrn_pkg::CAPACITY) begin
        r.st = rrrn_pkg::STATUS_FULL;
        return r;
      end
      s = ring_cursor;
      for (int i = 0; i < rrrn_pkg::CAPACITY; i++) begin
        s = rrrn_pkg::slot_t'((s + 1) % rrrn_pkg::CAPACITY);
        if (!ring_used[s]) break;
      end
      ring_cursor  = s;
      ring_val[s]  = v;
      ring_used[s] = 1'b1;
      if (ring_count == 0) begin
        ring_next[s] = s;
        ring_prev[s] = s;
        ring_front   = s;
      end else begin
        ring_prev[s]          = ring_back;
        ring_next[s]          = ring_front;
        ring_next[ring_back]  = s;
        ring_prev[ring_front] = s;
      end
      ring_back  = s;
      ring_count = ring_count + 1'b1;
    end else begin
      cur = ring_front;
      hit = 1'b0;
      d   = 0;
      while (d < ring_count) begin
        if (ring_val[cur] == v) begin
          hit = 1'b1;
          break;
        end
        cur = ring_next[cur];
        d++;
      end
      if (!hit) begin
        r.st = rrrn_pkg::STATUS_NOT_FOUND;
        return r;
      end
      r.rot = rrrn_pkg::rot_t'((d <= ring_count / 2) ? d : ring_count - d);
      nx = ring_next[cur];
      pv = ring_prev[cur];
      ring_used[cur] = 1'b0;
      ring_prev[nx]  = pv;
      ring_next[pv]  = nx;
      ring_front     = nx;
      ring_back      = pv;
      ring_count     = ring_count - 1'b1;
    end
    return r;
  endfunction

  // value held steps entries behind the front; only called on a non-empty ring
  function automatic rrrn_pkg::value_t value_at(int steps);
    rrrn_pkg::slot_t cur;
    cur = ring_front;
    repeat (steps) cur = ring_next[cur];
    return ring_val[cur];
  endfunction

  // small values collide often, which exercises first-occurrence search
  function automatic rrrn_pkg::value_t random_value();
    if ($urandom_range(4) < 2) return rrrn_pkg::value_t'($urandom);
    return rrrn_pkg::value_t'($urandom_range(0, 15));
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %0s", $realtime, msg);
  endtask

  // one input transfer; the expectation is formed at the accepting edge
  task automatic send_item(logic op, rrrn_pkg::value_t v);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    item_value <= v;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(ring_apply(op, v));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // removes mostly target a value present in the ring, at a random distance
  task automatic send_random(int push_pct);
    logic             op;
    rrrn_pkg::value_t v;
    if (ring_count == 0 || $urandom_range(99) < push_pct) begin
      op = rrrn_pkg::MODE_PUSH;
      v  = random_value();
    end else begin
      op = rrrn_pkg::MODE_REMOVE;
      if ($urandom_range(99) < 75) v = value_at($urandom_range(0, ring_count - 1));
      else v = random_value();
    end
    send_item(op, v);
  endtask

  task automatic test_directed();
    send_item(rrrn_pkg::MODE_REMOVE, 16'd5);     // empty ring
    send_item(rrrn_pkg::MODE_PUSH,   16'd0);     // first entry links to itself
    send_item(rrrn_pkg::MODE_REMOVE, 16'd0);     // ring empties again
    send_item(rrrn_pkg::MODE_REMOVE, 16'd0);
    send_item(rrrn_pkg::MODE_PUSH,   16'hFFFF);
    send_item(rrrn_pkg::MODE_PUSH,   16'd1);
    send_item(rrrn_pkg::MODE_PUSH,   16'd2);
    send_item(rrrn_pkg::MODE_PUSH,   16'd3);
    send_item(rrrn_pkg::MODE_PUSH,   16'd4);
    send_item(rrrn_pkg::MODE_PUSH,   16'd5);
    send_item(rrrn_pkg::MODE_REMOVE, 16'd3);     // distance exactly half the count
    send_item(rrrn_pkg::MODE_REMOVE, 16'd2);     // past half, backward rotation wins
    send_item(rrrn_pkg::MODE_REMOVE, 16'h8000);  // absent value
    send_item(rrrn_pkg::MODE_PUSH,   16'd7);
    send_item(rrrn_pkg::MODE_PUSH,   16'd7);
    send_item(rrrn_pkg::MODE_REMOVE, 16'd7);     // first of two duplicates
    send_item(rrrn_pkg::MODE_REMOVE, 16'd7);     // now at the front
    send_item(rrrn_pkg::MODE_REMOVE, 16'hFFFF);
    send_item(rrrn_pkg::MODE_REMOVE, 16'hAAAA);
    send_item(rrrn_pkg::MODE_PUSH,   16'h5555);
    idle_input();
  endtask

  task automatic test_fill_and_drain();
    while (ring_count < rrrn_pkg::CAPACITY) begin
      send_item(rrrn_pkg::MODE_PUSH, rrrn_pkg::value_t'($urandom));
    end
    repeat (3) send_item(rrrn_pkg::MODE_PUSH, random_value());
    send_item(rrrn_pkg::MODE_REMOVE, value_at(rrrn_pkg::CAPACITY / 2));  // longest rotation
    send_item(rrrn_pkg::MODE_PUSH, random_value());
    send_item(rrrn_pkg::MODE_REMOVE, value_at(rrrn_pkg::CAPACITY / 2 + 1));
    send_item(rrrn_pkg::MODE_REMOVE, value_at(ring_count - 1));
    while (ring_count > 0) begin
      send_item(rrrn_pkg::MODE_REMOVE, value_at($urandom_range(0, ring_count - 1)));
    end
    send_item(rrrn_pkg::MODE_REMOVE, random_value());
    idle_input();
  endtask

  task automatic test_random();
    int push_pct;
    for (int chunk = 0; chunk < 14; chunk++) begin
      case ($urandom_range(3))
        0: push_pct = 30;
        1: push_pct = 50;
        2: push_pct = 65;
        default: push_pct = 85;
      endcase
      quiet = ($urandom_range(4) == 0);
      repeat (100) send_random(push_pct);
    end
    quiet = 1'b0;
    idle_input();
  endtask

  // receiver holds off while the sender keeps offering, so the input side backs up
  task automatic test_backpressure();
    @(posedge clk);
    hold_req = 400;
    quiet    = 1'b1;
    repeat (12) send_random(60);
    quiet = 1'b0;
    idle_input();
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      run_stalled = 1'b1;
      run_left    = hold_req;
      hold_req    = 0;
    end else if (run_left == 0) begin
      if (quiet) begin
        run_stalled = 1'b0;
        run_left    = 16;
      end else begin
        stall_roll = $urandom_range(99);
        if (stall_roll < 55) begin
          run_stalled = 1'b0;
          run_left    = $urandom_range(1, 6);
        end else begin
          run_stalled = 1'b1;
          if (stall_roll < 90) run_left = $urandom_range(1, 3);
          else if (stall_roll < 98) run_left = $urandom_range(4, 12);
          else run_left = $urandom_range(20, 60);
        end
      end
    end
    out_stall <= run_stalled;
    if (run_left > 0) run_left--;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result: rotations %0d status %0d", rotations, status));
      end else begin
        oldest = pending_results.pop_front();
        if (rotations !== oldest.rot)
          report($sformatf("rotations: expected %0d, got %0d", oldest.rot, rotations));
        if (status !== oldest.st)
          report($sformatf("status: expected %0d, got %0d", oldest.st, status));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    ring_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_drain();
    test_random();
    test_backpressure();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rrrn_pkg.sv
hdl/rrrn_ram.sv
hdl/rotating_ring_remove_nearest_top.sv
dv/rotating_ring_remove_nearest_top_tb.sv
